[sv/polynomial_mutation_assert.svh]
// assertion macros shared by the polynomial mutation rtl
`ifndef POLYNOMIAL_MUTATION_ASSERT_SVH
`define POLYNOMIAL_MUTATION_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define PM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define PM_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/pm_pkg.sv]
// package with item types, constants and the root table function for polynomial mutation
`timescale 1ns / 1ps

package pm_pkg;

  localparam int DistIndex = 20;
  localparam int TabSize   = 257;
  localparam int RootIter  = 18;

  localparam logic [16:0] QOne    = 17'h10000;
  localparam logic [15:0] HalfDraw = 16'h8000;
  localparam logic [15:0] ThrReset = 16'd6554;

  typedef struct packed {
    logic signed [31:0] gene_value;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
    logic [15:0]        mutate_draw;
    logic [15:0]        spread_draw;
  } pm_in_t;

  typedef struct packed {
    logic signed [31:0] new_gene;
    logic               mutated;
  } pm_out_t;

  typedef struct packed {
    logic signed [31:0] gene;
    logic signed [32:0] span;
    logic               mutated;
    logic               lower;
    logic [16:0]        t;
  } pm_front_t;

  typedef struct packed {
    logic signed [31:0] gene;
    logic signed [32:0] span;
    logic               mutated;
    logic signed [17:0] delta;
  } pm_root_t;

  // r raised to DistIndex+1 in q16, truncating after each product
  function automatic logic [63:0] q16_power(input logic [63:0] r);
    logic [63:0] acc;
    acc = r;
    for (int n = 1; n < DistIndex + 1; n++) begin
      acc = (acc * r) >> 16;
    end
    return acc;
  endfunction

  // largest r in 0..1.0 with r^(DistIndex+1) <= k/256
  function automatic logic [16:0] root_entry(input int k);
    logic [63:0] target;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    target = 64'(k) << 8;
    lo = 64'd0;
    hi = 64'(QOne);
    for (int n = 0; n < RootIter; n++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (q16_power(mid) <= target) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    return lo[16:0];
  endfunction

endpackage

[sv/pm_front.sv]
// front stage: mutation decision, root argument and distance to the approached bound
`timescale 1ns / 1ps

module pm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [15:0]       thr_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  pm_pkg::pm_in_t    data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output pm_pkg::pm_front_t data_o
);
  import pm_pkg::*;

  logic        valid_q;
  pm_front_t   data_q;
  pm_front_t   data_d;
  logic [16:0] upper_gap;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    upper_gap      = QOne - {1'b0, data_i.spread_draw};
    data_d.gene    = data_i.gene_value;
    data_d.mutated = data_i.mutate_draw <= thr_i;
    data_d.lower   = data_i.spread_draw <= HalfDraw;
    if (data_d.lower) begin
      data_d.t    = {data_i.spread_draw, 1'b0};
      data_d.span = 33'(data_i.gene_value) - 33'(data_i.lower_bound);
    end else begin
      data_d.t    = {upper_gap[15:0], 1'b0};
      data_d.span = 33'(data_i.upper_bound) - 33'(data_i.gene_value);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[sv/pm_root.sv]
// root stages: table lookup, then interpolation and signed perturbation factor
`timescale 1ns / 1ps
`include "polynomial_mutation_assert.svh"

module pm_root (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  pm_pkg::pm_front_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output pm_pkg::pm_root_t  data_o
);
  import pm_pkg::*;

  typedef struct packed {
    logic signed [31:0] gene;
    logic signed [32:0] span;
    logic               mutated;
    logic               lower;
    logic [16:0]        base;
    logic [16:0]        diff;
    logic [7:0]         frac;
  } rt_stage_t;

  logic [16:0] tab [TabSize];

  for (genvar gk = 0; gk < TabSize; gk++) begin : g_tab
    assign tab[gk] = root_entry(gk);
  end

  logic        a_valid_q;
  logic        a_ready;
  rt_stage_t   a_q;
  rt_stage_t   a_d;
  logic [8:0]  idx;
  logic [8:0]  idx_lo;
  logic [8:0]  idx_hi;

  logic        b_valid_q;
  logic        b_ready;
  pm_root_t    b_q;
  pm_root_t    b_d;
  logic [24:0] interp;
  logic [16:0] root;

  assign b_ready = !b_valid_q || ready_i;
  assign a_ready = !a_valid_q || b_ready;
  assign ready_o = a_ready;

  // table lookup
  always_comb begin
    idx       = data_i.t[16:8];
    idx_lo    = (idx >= 9'(TabSize - 1)) ? 9'(TabSize - 1) : idx;
    idx_hi    = (idx >= 9'(TabSize - 1)) ? 9'(TabSize - 1) : idx + 9'd1;
    a_d.gene    = data_i.gene;
    a_d.span    = data_i.span;
    a_d.mutated = data_i.mutated;
    a_d.lower   = data_i.lower;
    a_d.base    = tab[idx_lo];
    a_d.diff    = tab[idx_hi] - tab[idx_lo];
    a_d.frac    = data_i.t[7:0];
  end

  // interpolation and sign by branch
  always_comb begin
    interp      = 25'(a_q.diff) * 25'(a_q.frac);
    root        = a_q.base + interp[24:8];
    b_d.gene    = a_q.gene;
    b_d.span    = a_q.span;
    b_d.mutated = a_q.mutated;
    if (a_q.lower) begin
      b_d.delta = $signed({1'b0, root}) - $signed({1'b0, QOne});
    end else begin
      b_d.delta = $signed({1'b0, QOne}) - $signed({1'b0, root});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && valid_i) begin
      a_q <= a_d;
    end
    if (b_ready && a_valid_q) begin
      b_q <= b_d;
    end
  end

  assign valid_o = b_valid_q;
  assign data_o  = b_q;

  `PM_ASSERT_IMP(a_lower_delta_range, a_valid_q && a_q.lower,
                 b_d.delta <= 18'sd0 && b_d.delta >= -18'sd65536,
                 "lower branch factor out of range")
  `PM_ASSERT_IMP(a_upper_delta_range, a_valid_q && !a_q.lower,
                 b_d.delta >= 18'sd0 && b_d.delta <= 18'sd65536,
                 "upper branch factor out of range")
  `PM_ASSERT_NXT(a_item_advances, a_valid_q && b_ready, b_valid_q,
                 "item lost between root stages")

endmodule

[sv/pm_scale.sv]
// scale stages: product with distance, truncation toward zero, add and saturate
`timescale 1ns / 1ps

module pm_scale (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  pm_pkg::pm_root_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output pm_pkg::pm_out_t  data_o
);
  import pm_pkg::*;

  logic               m_valid_q;
  logic               m_ready;
  logic signed [31:0] m_gene_q;
  logic               m_mut_q;
  logic signed [50:0] m_prod_q;
  logic signed [50:0] m_prod_d;

  logic               s_valid_q;
  logic               s_ready;
  logic signed [31:0] s_gene_q;
  logic               s_mut_q;
  logic signed [34:0] s_step_q;
  logic signed [34:0] s_step_d;
  logic signed [50:0] biased;

  logic               o_valid_q;
  logic               o_ready;
  pm_out_t            o_q;
  pm_out_t            o_d;
  logic signed [35:0] sum;

  assign o_ready = !o_valid_q || ready_i;
  assign s_ready = !s_valid_q || o_ready;
  assign m_ready = !m_valid_q || s_ready;
  assign ready_o = m_ready;

  assign m_prod_d = 51'(data_i.delta) * 51'(data_i.span);

  // divide by 2^16 rounding toward zero
  always_comb begin
    biased   = m_prod_q + (m_prod_q[50] ? 51'sd65535 : 51'sd0);
    s_step_d = 35'(biased >>> 16);
  end

  always_comb begin
    sum        = 36'(s_gene_q) + 36'(s_step_q);
    o_d.mutated = s_mut_q;
    if (!s_mut_q) begin
      o_d.new_gene = s_gene_q;
    end else if (sum[35] && !(&sum[34:31])) begin
      o_d.new_gene = 32'sh8000_0000;
    end else if (!sum[35] && (|sum[34:31])) begin
      o_d.new_gene = 32'sh7fff_ffff;
    end else begin
      o_d.new_gene = sum[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (m_ready) begin
        m_valid_q <= valid_i;
      end
      if (s_ready) begin
        s_valid_q <= m_valid_q;
      end
      if (o_ready) begin
        o_valid_q <= s_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_ready && valid_i) begin
      m_gene_q <= data_i.gene;
      m_mut_q  <= data_i.mutated;
      m_prod_q <= m_prod_d;
    end
    if (s_ready && m_valid_q) begin
      s_gene_q <= m_gene_q;
      s_mut_q  <= m_mut_q;
      s_step_q <= s_step_d;
    end
    if (o_ready && s_valid_q) begin
      o_q <= o_d;
    end
  end

  assign valid_o = o_valid_q;
  assign data_o  = o_q;

endmodule

[sv/polynomial_mutation.sv]
// polynomial mutation top level: threshold register and six-stage gene pipeline
// throughput: one item per cycle; each stage holds its item only while the next one is full
// reset: all stage valid bits clear, threshold returns to 6554
// the root table is constant logic, so no clearing pass follows reset
`timescale 1ns / 1ps
`include "polynomial_mutation_assert.svh"

module polynomial_mutation (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [15:0]     cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pm_pkg::pm_in_t  in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pm_pkg::pm_out_t out_o
);
  import pm_pkg::*;

  logic [15:0] thr_q;
  logic [15:0] thr_d;

  logic        fr_valid;
  logic        fr_ready;
  pm_front_t   fr_data;
  logic        rt_valid;
  logic        rt_ready;
  pm_root_t    rt_data;

  assign thr_d = cfg_we_i ? cfg_wdata_i : thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else begin
      thr_q <= thr_d;
    end
  end

  pm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .thr_i   (thr_q),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_i),
    .valid_o (fr_valid),
    .ready_i (fr_ready),
    .data_o  (fr_data)
  );

  pm_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .ready_o (fr_ready),
    .data_i  (fr_data),
    .valid_o (rt_valid),
    .ready_i (rt_ready),
    .data_o  (rt_data)
  );

  pm_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rt_valid),
    .ready_o (rt_ready),
    .data_i  (rt_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_o)
  );

  `PM_ASSERT_IMP(a_empty_output_takes_item, !out_valid_o, in_ready_o,
                 "input stalled while output register is empty")

endmodule
